@@ hdl/lszp_pkg.sv @@
// ----------------------------------------------------------------------------
// lszp_pkg
// Shared constants, types and helpers of the line sort and zigzag placer.
// ----------------------------------------------------------------------------
package lszp_pkg;

  localparam int LINE_MAX = 64;
  localparam int SAMPLE_W = 32;
  localparam int IDX_W    = $clog2(LINE_MAX);
  localparam int CNT_W    = $clog2(LINE_MAX + 1);

  localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'(LINE_MAX);
  localparam logic [CNT_W-1:0] LEN_MAX   = CNT_W'(LINE_MAX);
  localparam logic [CNT_W-1:0] LEN_MIN   = CNT_W'(1);

  typedef struct packed {
    logic load;   // insert the offered sample into the sorted cells
    logic shift;  // move every cell one place toward cell zero
  } cmd_t;

  typedef struct packed {
    logic             line_done;  // the offered sample completes the line
    logic [CNT_W-1:0] len;        // effective line length, 1 to LINE_MAX
  } status_t;

  // Flipping the sign bit gives an unsigned key with two's complement order.
  function automatic logic [SAMPLE_W-1:0] order_key(input logic [SAMPLE_W-1:0] v);
    order_key = {~v[SAMPLE_W-1], v[SAMPLE_W-2:0]};
  endfunction

endpackage

@@ hdl/line_sort_zigzag_placer_core.sv @@
// ----------------------------------------------------------------------------
// line_sort_zigzag_placer_core
// Collects a line of samples into sorted cells, then emits each value with its
// zigzag destination position, smallest at the right end.
// ----------------------------------------------------------------------------
// Each sample is loaded with its sorted insert as it arrives, while busy is low.
// The first result comes in the cycle after the last sample of a line, and the
// line's results then come one per cycle while busy is high.
// Reset sets the line length to 64 and empties the line; results cannot stall.
// ----------------------------------------------------------------------------
module line_sort_zigzag_placer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [lszp_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                           cfg_wr_en,
  input  logic [lszp_pkg::CNT_W-1:0]     cfg_wr_data,
  output logic                           strobe,
  output logic [lszp_pkg::IDX_W-1:0]     position,
  output logic signed [lszp_pkg::SAMPLE_W-1:0] value,
  output logic                           end_of_line
);
  import lszp_pkg::*;

  cmd_t    cmd;
  status_t status;

  lszp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .status      (status),
    .cmd         (cmd),
    .strobe      (strobe),
    .position    (position),
    .end_of_line (end_of_line)
  );

  lszp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_value (sample_value),
    .cmd          (cmd),
    .status       (status),
    .value        (value)
  );

endmodule

@@ hdl/lszp_datapath.sv @@
// ----------------------------------------------------------------------------
// lszp_datapath
// Length register, fill count and a row of insertion sort cells that unload
// by shifting toward cell zero.
// ----------------------------------------------------------------------------
module lszp_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lszp_pkg::CNT_W-1:0]     cfg_wr_data,
  input  logic signed [lszp_pkg::SAMPLE_W-1:0] sample_value,
  input  lszp_pkg::cmd_t                 cmd,
  output lszp_pkg::status_t              status,
  output logic signed [lszp_pkg::SAMPLE_W-1:0] value
);
  import lszp_pkg::*;

  logic [CNT_W-1:0]    len;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    fill_inc;
  logic [SAMPLE_W-1:0] cells [LINE_MAX];
  logic [LINE_MAX-1:0] lt;

  assign fill_inc         = fill + CNT_W'(1);
  assign status.line_done = (fill_inc == len);
  assign status.len       = len;
  assign value            = signed'(cells[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= LEN_RESET;
      fill <= '0;
    end else if (cfg_wr_en) begin
      // Any write drops a partial line.
      fill <= '0;
      if (cfg_wr_data == '0) begin
        len <= LEN_MIN;
      end else if (cfg_wr_data > LEN_MAX) begin
        len <= LEN_MAX;
      end else begin
        len <= cfg_wr_data;
      end
    end else if (cmd.load) begin
      fill <= status.line_done ? '0 : fill_inc;
    end
  end

  // Cells at or beyond the fill count hold nothing and compare as infinite.
  always_comb begin
    for (int i = 0; i < LINE_MAX; i++) begin
      lt[i] = (CNT_W'(i) >= fill) ||
              (order_key(sample_value) < order_key(cells[i]));
    end
  end

  for (genvar g = 0; g < LINE_MAX; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.load && lt[g]) begin
        if (g == 0) begin
          cells[g] <= sample_value;
        end else begin
          // The first cell above the new word takes it; the rest move up.
          cells[g] <= lt[(g == 0) ? 0 : g - 1] ? cells[(g == 0) ? 0 : g - 1]
                                               : sample_value;
        end
      end else if (cmd.shift) begin
        cells[g] <= cells[(g == LINE_MAX - 1) ? g : g + 1];
      end
    end
  end

endmodule

@@ hdl/lszp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lszp_ctrl
// Load and unload sequencer: counts the rank of each result and derives its
// destination position and end of line mark.
// ----------------------------------------------------------------------------
module lszp_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lszp_pkg::status_t          status,
  output lszp_pkg::cmd_t             cmd,
  output logic                       strobe,
  output logic [lszp_pkg::IDX_W-1:0] position,
  output logic                       end_of_line
);
  import lszp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state;
  logic             state_next;
  logic [IDX_W-1:0] rank;
  logic [IDX_W-1:0] rank_next;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] far_pos;
  logic             last_rank;

  assign busy      = (state == ST_EMIT);
  assign cmd.load  = start && !busy;
  assign cmd.shift = busy;
  assign strobe    = busy;

  assign half        = {1'b0, rank} >> 1;
  assign far_pos     = status.len - CNT_W'(1) - half;
  assign last_rank   = ({1'b0, rank} == status.len - CNT_W'(1));
  // Odd ranks fill from the left, even ranks from the right.
  assign position    = rank[0] ? half[IDX_W-1:0] : far_pos[IDX_W-1:0];
  assign end_of_line = busy && last_rank;

  always_comb begin
    state_next = state;
    rank_next  = rank;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load && status.line_done) begin
          state_next = ST_EMIT;
          rank_next  = '0;
        end
      end
      ST_EMIT: begin
        rank_next = rank + IDX_W'(1);
        if (last_rank) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rank  <= '0;
    end else begin
      state <= state_next;
      rank  <= rank_next;
    end
  end

  a_emit_after_line: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && status.line_done) |=> (strobe && rank == '0))
    else $error("line completion not followed by first result");

  a_rank_in_line: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ({1'b0, rank} < status.len))
    else $error("result rank beyond line length");

  a_eol_ends_burst: assert property (@(posedge clk) disable iff (rst)
    end_of_line |=> !strobe)
    else $error("result after end of line");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("sample loaded while unloading");

endmodule

@@ tb/sv/line_sort_zigzag_placer_checker.sv @@
// ----------------------------------------------------------------------------
// line_sort_zigzag_placer_checker
// Watches the sample, configuration and result channels of the line sort
// placer. It keeps its own copy of the line and the line length, sorts each
// completed line and compares every result word with the predicted placement.
// ----------------------------------------------------------------------------
module line_sort_zigzag_placer_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [lszp_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                 cfg_wr_en,
  input  logic [lszp_pkg::CNT_W-1:0]           cfg_wr_data,
  input  logic                                 strobe,
  input  logic [lszp_pkg::IDX_W-1:0]           position,
  input  logic signed [lszp_pkg::SAMPLE_W-1:0] value,
  input  logic                                 end_of_line,
  output int                                   mismatch_count,
  output int                                   pending_count
);
  import lszp_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [IDX_W-1:0]           pos;
    logic signed [SAMPLE_W-1:0] val;
    logic                       eol;
  } placement_t;

  placement_t                 placement_q[$];
  logic signed [SAMPLE_W-1:0] line_buf [LINE_MAX];
  logic [CNT_W-1:0]           line_len_reg;
  int                         fill;

  // A length of zero behaves as one, and anything above the store depth saturates.
  function automatic int active_length(input logic [CNT_W-1:0] len);
    if (len == '0) return 1;
    if (int'(len) > LINE_MAX) return LINE_MAX;
    return int'(len);
  endfunction

  task automatic place_sample(input logic signed [SAMPLE_W-1:0] s);
    int                         n;
    int                         i;
    int                         j;
    logic signed [SAMPLE_W-1:0] ranked [LINE_MAX];
    logic signed [SAMPLE_W-1:0] cur;
    placement_t                 p;
    n = active_length(line_len_reg);
    if (fill >= n) fill = 0;
    line_buf[fill] = s;
    fill++;
    if (fill < n) return;
    for (i = 0; i < n; i++) ranked[i] = line_buf[i];
    for (i = 1; i < n; i++) begin
      cur = ranked[i];
      j = i;
      while (j > 0 && ranked[j-1] > cur) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = cur;
    end
    // Odd ranks fill from the left end, even ranks from the right end inward.
    for (i = 0; i < n; i++) begin
      p.pos = (i % 2 != 0) ? IDX_W'(i / 2) : IDX_W'(n - 1 - i / 2);
      p.val = ranked[i];
      p.eol = (i == n - 1);
      placement_q.push_back(p);
    end
    fill = 0;
  endtask

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      placement_q.delete();
      line_len_reg   = LEN_RESET;
      fill           = 0;
      mismatch_count = 0;
    end else begin
      if (strobe) begin
        if (placement_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected word: pos=%0d value=%0d eol=%0b",
                     position, value, end_of_line);
        end else begin
          want = placement_q.pop_front();
          if (want.pos !== position || want.val !== value || want.eol !== end_of_line) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display(
                "mismatch: expected pos=%0d value=%0d eol=%0b, got pos=%0d value=%0d eol=%0b",
                want.pos, want.val, want.eol, position, value, end_of_line);
          end
        end
      end
      // Any write to the length drops a partially collected line.
      if (cfg_wr_en) begin
        line_len_reg = cfg_wr_data;
        fill         = 0;
      end
      if (start && !busy) place_sample(sample_value);
    end
    pending_count = placement_q.size();
  end

endmodule

@@ tb/sv/tb_line_sort_zigzag_placer_core.sv @@
// ----------------------------------------------------------------------------
// tb_line_sort_zigzag_placer_core
// Drives lines of samples into the line sort placer under several line
// lengths, with bursty input timing, and lets the checker judge the results.
// ----------------------------------------------------------------------------
module tb_line_sort_zigzag_placer_core;
  import lszp_pkg::*;

  localparam int RANDOM_ITEMS = 270;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 16;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       cfg_wr_en;
  logic [CNT_W-1:0]           cfg_wr_data;
  logic                       strobe;
  logic [IDX_W-1:0]           position;
  logic signed [SAMPLE_W-1:0] value;
  logic                       end_of_line;
  int                         mismatch_count;
  int                         pending_count;
  int                         burst_left;

  line_sort_zigzag_placer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_value (sample_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .strobe       (strobe),
    .position     (position),
    .value        (value),
    .end_of_line  (end_of_line)
  );

  line_sort_zigzag_placer_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .sample_value   (sample_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .strobe         (strobe),
    .position       (position),
    .value          (value),
    .end_of_line    (end_of_line),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Extremes, small values that tie often, and plain random words.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
      default: return $signed($urandom);
    endcase
  endfunction

  // Offers one word and returns at the edge that accepts it.
  task automatic feed(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start        <= 1'b1;
    sample_value <= s;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Holds off input until every predicted word has come out and the core is idle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [CNT_W-1:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int               items_sent;
    int               n;
    int               lines;
    int               extra;
    logic [CNT_W-1:0] len_code;
    int               r;
    rst          = 1'b1;
    start        = 1'b0;
    sample_value = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    burst_left   = 0;
    items_sent   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-sample lines at the extremes.
    write_length(CNT_W'(1));
    feed(32'sh7FFFFFFF);
    feed(32'sh80000000);
    feed(32'sd0);
    feed(-32'sd1);

    // Four-sample lines: extremes mixed, then a line full of ties.
    drain();
    write_length(CNT_W'(4));
    feed(32'sh7FFFFFFF);
    feed(32'sh80000000);
    feed(32'sd0);
    feed(-32'sd1);
    feed(32'sd5);
    feed(32'sd5);
    feed(-32'sd5);
    feed(32'sd5);

    // A length of zero behaves as one.
    drain();
    write_length('0);
    feed(-32'sd1);
    feed(32'sd1);

    // A partial line is dropped by the next length write.
    drain();
    write_length(CNT_W'(3));
    feed(32'sd77);
    feed(-32'sd77);
    drain();
    write_length(CNT_W'(3));
    feed(32'sd100);
    feed(-32'sd100);
    feed(32'sd0);
    drain();
    write_length(CNT_W'(2));
    feed(32'sd9);
    feed(-32'sd9);

    // Random phases; the first one saturates the length to a full line.
    len_code = '1;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      write_length(len_code);
      if (len_code == '0) n = 1;
      else if (int'(len_code) > LINE_MAX) n = LINE_MAX;
      else n = int'(len_code);
      lines = (n >= 32) ? 1 : $urandom_range(1, 4);
      for (int l = 0; l < lines; l++) begin
        for (int k = 0; k < n; k++) begin
          feed(pick_sample());
          items_sent++;
        end
        if ($urandom_range(0, 9) == 0) drain();
      end
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        extra = $urandom_range(1, n - 1);
        for (int k = 0; k < extra; k++) feed(pick_sample());
      end
      r = $urandom_range(0, 19);
      case (r)
        0:       len_code = '0;
        1:       len_code = CNT_W'(1);
        2:       len_code = LEN_MAX;
        3:       len_code = CNT_W'($urandom_range(65, 127));
        4:       len_code = '1;
        default: len_code = CNT_W'($urandom_range(2, 12));
      endcase
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
